/* rtl/core/ckhs_pkg.sv */
// ----------------------------------------------------------------------------
// ckhs_pkg: shared types and constants for the canonical k-mer hash set
// Holds field widths, the hash constants and the sequencer state type.
// ----------------------------------------------------------------------------
package ckhs_pkg;

    localparam int KEY_W       = 64;
    localparam int LEN_W       = 6;
    localparam int SLOTS_W     = 13;
    localparam int SLOT_OUT_W  = 12;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int DEF_DEPTH   = 4096;

    localparam logic [LEN_W-1:0]   LEN_RESET   = 6'd21;
    localparam logic [SLOTS_W-1:0] SLOTS_RESET = 13'd4096;
    localparam logic [31:0]        HASH_MUL    = 32'h045d9f3b;
    localparam int                 HASH_SHIFT  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SLOTS = 1'b1;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Operations of the shared arithmetic unit.
    typedef enum logic [2:0] {
        OP_XSH,      // x ^= x >> 16
        OP_MUL_LO,   // acc = x[31:0] * M
        OP_MUL_HI,   // acc += x[63:32] * M << 32
        OP_REVC,     // one reverse-complement step, eight bases
        OP_MOD       // one restoring division step
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_REVC,
        ST_XSH,
        ST_MLO,
        ST_MHI,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

endpackage

/* rtl/core/ckhs_stream_if.sv */
// ----------------------------------------------------------------------------
// ckhs_stream_if: valid/ready channel with a parameterized payload
// One instance carries the input items, another the result items.
// ----------------------------------------------------------------------------
interface ckhs_stream_if #(
    parameter int W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ckhs_ram.sv */
// ----------------------------------------------------------------------------
// ckhs_ram: generic single-port RAM
// One write or one read a cycle, read data registered.
// ----------------------------------------------------------------------------
module ckhs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* rtl/core/ckhs_alu.sv */
// ----------------------------------------------------------------------------
// ckhs_alu: shared arithmetic unit of the hash set
// Does the xorshift, the two halves of the 64x32 multiply, the
// reverse-complement steps and one bit of the modulo per cycle.
// ----------------------------------------------------------------------------
module ckhs_alu (
    input  logic                          clk,
    input  ckhs_pkg::alu_ctl_t            ctl,
    input  logic [ckhs_pkg::KEY_W-1:0]    load_val,
    input  logic [ckhs_pkg::SLOTS_W-1:0]  divisor,
    output logic [ckhs_pkg::KEY_W-1:0]    acc,
    output logic [ckhs_pkg::SLOTS_W-1:0]  rem
);
    import ckhs_pkg::*;

    logic [KEY_W-1:0]   acc_reg, acc_next;
    logic [KEY_W-1:0]   src_reg, src_next;
    logic [31:0]        quo_reg, quo_next;
    logic [SLOTS_W-1:0] rem_reg, rem_next;
    logic [SLOTS_W:0]   trial;
    logic [63:0]        prod;
    logic [31:0]        mul_in;

    assign mul_in = (ctl.op == OP_MUL_HI) ? src_reg[63:32] : src_reg[31:0];
    assign prod   = {32'd0, mul_in} * {32'd0, HASH_MUL};
    assign trial  = {rem_reg, quo_reg[31]};

    // One step of the selected operation per cycle.
    always_comb
    begin
        acc_next = acc_reg;
        src_next = src_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (ctl.start)
        begin
            acc_next = load_val;
            src_next = load_val;
            quo_next = load_val[31:0];
            rem_next = '0;
        end
        else
        begin
            case (ctl.op)
                OP_XSH:
                begin
                    acc_next = acc_reg ^ (acc_reg >> HASH_SHIFT);
                    src_next = acc_next;
                    quo_next = acc_next[31:0];
                end
                OP_MUL_LO:
                begin
                    acc_next = prod;
                end
                OP_MUL_HI:
                begin
                    acc_next = acc_reg + {prod[31:0], 32'd0};
                end
                OP_REVC:
                begin
                    // Take the eight lowest bases, complement them in reverse order, shift in at the low end.
                    acc_next = {acc_reg[47:0], ~src_reg[1:0], ~src_reg[3:2], ~src_reg[5:4],
                                ~src_reg[7:6], ~src_reg[9:8], ~src_reg[11:10],
                                ~src_reg[13:12], ~src_reg[15:14]};
                    src_next = src_reg >> 16;
                end
                OP_MOD:
                begin
                    quo_next = {quo_reg[30:0], 1'b0};
                    if (trial >= {1'b0, divisor})
                    begin
                        rem_next = SLOTS_W'(trial - {1'b0, divisor});
                    end
                    else
                    begin
                        rem_next = trial[SLOTS_W-1:0];
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        src_reg <= src_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign acc = acc_reg;
    assign rem = rem_reg;
endmodule

/* rtl/core/canonical_kmer_hash_set.sv */
// ----------------------------------------------------------------------------
// canonical_kmer_hash_set: open-addressed hash set of 2-bit packed k-mers
// Insert and canonical lookup with linear probing over a key RAM.
// ----------------------------------------------------------------------------
// An insert hashes the key (three xorshifts and two multiplies, each split
// into a low and a high half), reduces the hash modulo the slot count one bit
// a cycle and then reads and checks one slot per probe. A lookup first runs
// the reverse complement and picks the canonical key, then hashes and probes
// the same way. The input is ready only when the sequencer is idle and no
// result waits, so a new item is taken only after the last result has been
// taken. The shared unit and the single-port RAMs make these steps run in turn.
// After reset a clearing pass over all TABLE_DEPTH entries zeroes the
// occupancy RAM; no item is accepted then.
module canonical_kmer_hash_set #(
    parameter int TABLE_DEPTH = ckhs_pkg::DEF_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ckhs_stream_if.sink                         in_ch,
    ckhs_stream_if.source                       out_ch,
    input  logic                                cfg_we,
    input  logic [ckhs_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [ckhs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ckhs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = AW + 1;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    len_reg;
    logic [SLOTS_W-1:0]  slots_reg;
    logic                act_reg, act_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [PW-1:0]       probes_reg, probes_next;
    logic                found_reg, found_next;
    logic                status_reg, status_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic                ovalid_reg, ovalid_next;
    logic [SLOTS_W-1:0]  used_cnt_reg, used_cnt_next;

    logic [5:0]          k_eff;
    logic [PW-1:0]       n_eff;
    logic [KEY_W-1:0]    kmask, in_key, rc_aligned;
    alu_ctl_t            alu_ctl;
    logic [KEY_W-1:0]    alu_load, alu_acc;
    logic [SLOTS_W-1:0]  alu_rem;
    logic                ram_we, used_we, used_wd, used_rd;
    logic [AW-1:0]       ram_addr;
    logic [KEY_W-1:0]    key_rd;
    logic [PW-1:0]       pos_wide;

    // Effective k and slot count.
    always_comb
    begin
        if (len_reg == '0)
        begin
            k_eff = 6'd1;
        end
        else if (len_reg > 6'd32)
        begin
            k_eff = 6'd32;
        end
        else
        begin
            k_eff = len_reg;
        end
        if (slots_reg == '0)
        begin
            n_eff = PW'(1);
        end
        else if (32'(slots_reg) > 32'(TABLE_DEPTH))
        begin
            n_eff = PW'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = PW'(slots_reg);
        end
    end

    assign kmask  = (k_eff >= 6'd32) ? '1 : ((64'd1 << {k_eff, 1'b0}) - 64'd1);
    assign in_key = in_ch.data[KEY_W-1:0] & kmask;
    // The unit reverses all 32 base positions; drop the unused low ones.
    assign rc_aligned = alu_acc >> {6'd32 - k_eff, 1'b0};
    assign pos_wide   = {1'b0, pos_reg};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LEN_RESET;
            slots_reg <= SLOTS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_KMER_LENGTH: len_reg   <= cfg_data[LEN_W-1:0];
                REG_TABLE_SLOTS: slots_reg <= cfg_data;
                default:         len_reg   <= len_reg;
            endcase
        end
    end

    ckhs_alu u_alu (
        .clk      (clk),
        .ctl      (alu_ctl),
        .load_val (alu_load),
        .divisor  (SLOTS_W'(n_eff)),
        .acc      (alu_acc),
        .rem      (alu_rem)
    );

    ckhs_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_keys (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(key_reg), .rdata(key_rd)
    );

    ckhs_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_used (
        .clk(clk), .we(used_we), .addr(ram_addr), .wdata(used_wd), .rdata(used_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            pos_reg      <= '0;
            ovalid_reg   <= 1'b0;
            used_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pos_reg      <= pos_next;
            ovalid_reg   <= ovalid_next;
            used_cnt_reg <= used_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        probes_reg <= probes_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    // Sequencer: next state, unit control and RAM access.
    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        key_next      = key_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        probes_next   = probes_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        ovalid_next   = ovalid_reg;
        used_cnt_next = used_cnt_reg;
        alu_ctl.start = 1'b0;
        alu_ctl.op    = OP_XSH;
        alu_load      = key_reg;
        ram_we        = 1'b0;
        used_we       = 1'b0;
        used_wd       = 1'b0;
        ram_addr      = pos_reg;
        in_ch.ready   = 1'b0;

        if (out_ch.valid && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                used_we  = 1'b1;
                pos_next = pos_reg + AW'(1);
                if (pos_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ch.ready = !ovalid_reg;
                if (in_ch.valid && !ovalid_reg)
                begin
                    act_next      = in_ch.data[KEY_W];
                    key_next      = in_key;
                    alu_ctl.start = 1'b1;
                    alu_load      = in_key;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    status_next   = 1'b0;
                    slot_next     = '0;
                    probes_next   = '0;
                    state_next    = (in_ch.data[KEY_W] == ACT_LOOKUP) ? ST_REVC : ST_XSH;
                end
            end
            ST_REVC:
            begin
                alu_ctl.op = OP_REVC;
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3)
                begin
                    cnt_next = '0;
                    state_next = ST_DONE;
                    // Reload with the canonical key next cycle via DONE path.
                end
            end
            ST_XSH:
            begin
                alu_ctl.op = OP_XSH;
                if (cnt_reg == 6'd4)
                begin
                    cnt_next   = '0;
                    state_next = ST_MOD;
                end
                else
                begin
                    cnt_next   = cnt_reg + 6'd1;
                    state_next = ST_MLO;
                end
            end
            ST_MLO:
            begin
                alu_ctl.op = OP_MUL_LO;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                alu_ctl.op = OP_MUL_HI;
                cnt_next   = cnt_reg + 6'd1;
                state_next = ST_XSH;
            end
            ST_MOD:
            begin
                alu_ctl.op = OP_MOD;
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (probes_reg == '0)
                begin
                    pos_next = AW'(alu_rem);
                    ram_addr = AW'(alu_rem);
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (act_reg == ACT_INSERT)
                begin
                    if (!used_rd)
                    begin
                        ram_we        = 1'b1;
                        used_we       = 1'b1;
                        used_wd       = 1'b1;
                        used_cnt_next = used_cnt_reg + SLOTS_W'(1);
                        slot_next     = SLOT_OUT_W'(pos_reg);
                        state_next    = ST_IDLE;
                        ovalid_next   = 1'b1;
                    end
                end
                else if (!used_rd)
                begin
                    state_next  = ST_IDLE;
                    ovalid_next = 1'b1;
                end
                else if (key_rd == key_reg)
                begin
                    found_next  = 1'b1;
                    slot_next   = SLOT_OUT_W'(pos_reg);
                    state_next  = ST_IDLE;
                    ovalid_next = 1'b1;
                end
                if (state_next == ST_CHECK)
                begin
                    probes_next = probes_reg + PW'(1);
                    if (pos_wide + PW'(1) >= n_eff)
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + AW'(1);
                    end
                    if (probes_reg + PW'(1) >= n_eff)
                    begin
                        status_next = (act_reg == ACT_INSERT);
                        slot_next   = '0;
                        state_next  = ST_IDLE;
                        ovalid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_DONE:
            begin
                // Pick the canonical key and restart the unit on it.
                alu_ctl.start = 1'b1;
                if (rc_aligned < key_reg)
                begin
                    alu_load = rc_aligned;
                    key_next = rc_aligned;
                end
                state_next = ST_XSH;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = {found_reg, status_reg, slot_reg};

    // Checks on the sequencer.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |-> (state_reg == ST_IDLE && !ovalid_reg))
        else $error("item accepted while busy");
    a_lookup_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && act_reg == ACT_LOOKUP) |-> !out_ch.data[SLOT_OUT_W])
        else $error("lookup reported full");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        used_we && used_wd |=> used_cnt_reg == $past(used_cnt_reg) + SLOTS_W'(1))
        else $error("occupancy count slipped");
endmodule

/* test/canonical_kmer_hash_set_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_kmer_hash_set_tb: self-checking bench for the k-mer hash set
// Drives inserts and canonical lookups over several length and slot-count
// settings and checks every result against a local model of the table.
// ----------------------------------------------------------------------------
module canonical_kmer_hash_set_tb;
    import ckhs_pkg::*;

    localparam int DEPTH      = DEF_DEPTH;
    localparam int IN_W       = 1 + KEY_W;
    localparam int OUT_W      = 2 + SLOT_OUT_W;
    localparam int STALL_MAX  = 50000;
    localparam int DRAIN_CYC  = 200;

    typedef struct packed {
        logic                  found;
        logic                  status;
        logic [SLOT_OUT_W-1:0] slot;
    } answer_t;

    typedef struct {
        logic         act;
        logic [63:0]  key;
        bit           typed;
        answer_t      ans;
    } row_t;

    typedef struct {
        int k;
        int n;
        int items;
    } phase_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ckhs_stream_if #(.W(IN_W))  in_ch ();
    ckhs_stream_if #(.W(OUT_W)) out_ch ();

    canonical_kmer_hash_set #(.TABLE_DEPTH(DEPTH)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // Model of the table and its settings.
    bit [63:0] model_keys [DEPTH];
    bit        model_used [DEPTH];
    int        model_len;
    int        model_slots;

    answer_t   pending_answers[$];
    logic [63:0] stored_keys[$];
    int        error_count;
    int        idle_cycles = 0;
    int        send_idle_pct;
    int        recv_idle_pct;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int eff_len();
        if (model_len < 1) return 1;
        if (model_len > 32) return 32;
        return model_len;
    endfunction

    function automatic int eff_slots();
        if (model_slots < 1) return 1;
        if (model_slots > DEPTH) return DEPTH;
        return model_slots;
    endfunction

    function automatic logic [63:0] len_mask(int k);
        if (k >= 32) return '1;
        return (64'd1 << (2 * k)) - 64'd1;
    endfunction

    function automatic logic [63:0] rev_comp_key(logic [63:0] key, int k);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < k; i++)
            r[2 * (k - 1 - i) +: 2] = 2'd3 - key[2 * i +: 2];
        return r;
    endfunction

    function automatic logic [31:0] kmer_hash(logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = ((x >> HASH_SHIFT) ^ x) * {32'd0, HASH_MUL};
        x = ((x >> HASH_SHIFT) ^ x) * {32'd0, HASH_MUL};
        x = (x >> HASH_SHIFT) ^ x;
        return x[31:0];
    endfunction

    // Applies one item to the table model and returns the expected answer.
    function automatic answer_t table_answer(logic act, logic [63:0] code);
        int          k;
        int          n;
        int          pos;
        logic [63:0] key;
        logic [63:0] canon;
        answer_t     a;
        k   = eff_len();
        n   = eff_slots();
        key = code & len_mask(k);
        a   = '0;
        if (act == ACT_INSERT)
        begin
            pos = kmer_hash(key) % n;
            a.status = 1'b1;
            for (int p = 0; p < n; p++)
            begin
                if (!model_used[pos])
                begin
                    model_used[pos] = 1'b1;
                    model_keys[pos] = key;
                    a.slot   = pos[SLOT_OUT_W-1:0];
                    a.status = 1'b0;
                    break;
                end
                pos = (pos + 1 >= n) ? 0 : pos + 1;
            end
        end
        else
        begin
            canon = rev_comp_key(key, k);
            if (key < canon)
                canon = key;
            pos = kmer_hash(canon) % n;
            for (int p = 0; p < n; p++)
            begin
                if (!model_used[pos])
                    break;
                if (model_keys[pos] == canon)
                begin
                    a.found = 1'b1;
                    a.slot  = pos[SLOT_OUT_W-1:0];
                    break;
                end
                pos = (pos + 1 >= n) ? 0 : pos + 1;
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Register write on the configuration port, one cycle wide.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we   = 1'b0;
        if (idx == REG_KMER_LENGTH)
            model_len = value & 6'h3F;
        else
            model_slots = value & 13'h1FFF;
    endtask

    // One transfer on the input channel; the expectation is queued on accept.
    task automatic send_item(logic act, logic [63:0] code, bit typed, answer_t ans);
        answer_t a;
        if ($urandom_range(99) < send_idle_pct)
            repeat ($urandom_range(4, 1)) @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.data  = {act, code};
        do
            @(posedge clk);
        while (!in_ch.ready);
        a = table_answer(act, code);
        if (typed && a != ans)
            report_mismatch("typed row vs model", a, ans);
        pending_answers.push_back(a);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Receiver stalls.
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Result checking and the stall watchdog.
    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (pending_answers.size() == 0)
                report_mismatch("unexpected result, slot", got.slot, 0);
            else
            begin
                want = pending_answers.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", got.found, want.found);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.slot !== want.slot)
                    report_mismatch("slot", got.slot, want.slot);
            end
        end
        if (idle_cycles >= STALL_MAX)
        begin
            $display("canonical_kmer_hash_set_tb: done, errors");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        row_t        rows[$];
        phase_t      phases[$];
        logic [63:0] key;
        logic        act;
        int          pick;
        answer_t     none;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = REG_KMER_LENGTH;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        error_count   = 0;
        send_idle_pct = 38;
        recv_idle_pct = 78;
        model_len     = LEN_RESET;
        model_slots   = SLOTS_RESET;
        none          = '0;
        foreach (model_used[i])
            model_used[i] = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows at reset settings: empty table, extremes, canonical pairs.
        rows = '{
            '{ACT_LOOKUP, 64'h0,                 1, '0},
            '{ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1, '0},
            '{ACT_INSERT, 64'h0,                 0, '0},
            '{ACT_LOOKUP, 64'h0,                 0, '0},
            '{ACT_LOOKUP, 64'h3FF_FFFF_FFFF,     0, '0},
            '{ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 0, '0},
            '{ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 0, '0},
            '{ACT_INSERT, 64'h0123_4567_89AB_CDEF, 0, '0},
            '{ACT_INSERT, 64'h0123_4567_89AB_CDEF, 0, '0},
            '{ACT_LOOKUP, 64'hFEDC_BA98_7654_3210, 0, '0},
            '{ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0},
            '{ACT_LOOKUP, 64'h5555_5555_5555_5555, 0, '0},
            '{ACT_LOOKUP, 64'h1B1B_1B1B_1B1B_1B1B, 0, '0}
        };
        foreach (rows[i])
            send_item(rows[i].act, rows[i].key, rows[i].typed, rows[i].ans);

        // Single-slot table: slot 0 still holds key 0 from the rows above, so the inserts are refused.
        wait_drained();
        write_reg(REG_TABLE_SLOTS, 1);
        write_reg(REG_KMER_LENGTH, 1);
        send_item(ACT_LOOKUP, 64'h2, 0, none);
        send_item(ACT_INSERT, 64'h2, 0, none);
        send_item(ACT_INSERT, 64'h1, 0, none);
        send_item(ACT_LOOKUP, 64'h1, 0, none);
        send_item(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 0, none);

        // The last two phases use out-of-range length and slot-count values.
        phases = '{
            '{32, 16, 70}, '{1, 5, 60}, '{7, 64, 80},
            '{32, 4096, 60}, '{12, 200, 90}, '{3, 37, 70},
            '{21, 4096, 60}, '{32, 9, 70}, '{17, 128, 90},
            '{0, 0, 20}, '{45, 8000, 30}
        };
        foreach (phases[p])
        begin
            if (p == 3)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 38;
            end
            else if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Sender holds off until the block is idle before reconfiguring.
            wait_drained();
            write_reg(REG_KMER_LENGTH, phases[p].k);
            write_reg(REG_TABLE_SLOTS, phases[p].n);
            stored_keys.delete();
            for (int i = 0; i < phases[p].items; i++)
            begin
                key  = {$urandom, $urandom};
                pick = $urandom_range(99);
                act  = (pick < 45) ? ACT_INSERT : ACT_LOOKUP;
                if (act == ACT_INSERT)
                begin
                    // Half the inserts store the canonical form.
                    if (pick < 22)
                    begin
                        key = key & len_mask(eff_len());
                        if (rev_comp_key(key, eff_len()) < key)
                            key = rev_comp_key(key, eff_len());
                    end
                    stored_keys.push_back(key & len_mask(eff_len()));
                end
                else if (pick < 90 && stored_keys.size() != 0)
                begin
                    key = stored_keys[$urandom_range(stored_keys.size() - 1)];
                    if (pick < 68)
                        key = rev_comp_key(key, eff_len());
                    if (pick < 56)
                        key = key | ({$urandom, $urandom} & ~len_mask(eff_len()));
                end
                send_item(act, key, 0, none);
            end
        end

        wait_drained();
        repeat (DRAIN_CYC) @(negedge clk);
        if (error_count == 0 && pending_answers.size() == 0)
            $display("canonical_kmer_hash_set_tb: done, clean");
        else
            $display("canonical_kmer_hash_set_tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ckhs_pkg.sv
rtl/core/ckhs_stream_if.sv
rtl/core/ckhs_ram.sv
rtl/core/ckhs_alu.sv
rtl/core/canonical_kmer_hash_set.sv
test/canonical_kmer_hash_set_tb.sv
